>>> rtl/tlfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_pkg
// shared types and constants for the three-level feedback queue scheduler
// ----------------------------------------------------------------------------
package tlfq_pkg;

  localparam int TableDepth = 32;
  localparam int SlotW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] ModeInsert  = 2'd0;
  localparam logic [1:0] ModeRemove  = 2'd1;
  localparam logic [1:0] ModeAge     = 2'd2;
  localparam logic [1:0] ModePreempt = 2'd3;

  localparam logic [1:0] LevelNone = 2'd0;
  localparam logic [1:0] Level1    = 2'd1;
  localparam logic [1:0] Level2    = 2'd2;
  localparam logic [1:0] Level3    = 2'd3;

  localparam logic [2:0] RegL1Floor   = 3'd0;
  localparam logic [2:0] RegL2Floor   = 3'd1;
  localparam logic [2:0] RegAgingThr  = 3'd2;
  localparam logic [2:0] RegAgingStep = 3'd3;
  localparam logic [2:0] RegPrioCap   = 3'd4;
  localparam logic [2:0] RegQuantum   = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] thread_id;
    logic [7:0]  priority_req;
    logic signed [31:0] remaining_time;
    logic [31:0] now_tick;
    logic [1:0]  running_level;
    logic signed [31:0] running_remaining;
    logic [31:0] running_burst;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [1:0]  out_level;
    logic        all_empty;
    logic        preempt;
    logic        dropped;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  level;
    logic [7:0]  prio;
    logic [31:0] sort_key;
    logic [31:0] ready_since;
    logic [15:0] order;
  } entry_t;

  typedef struct packed {
    logic [7:0]  l1_floor;
    logic [7:0]  l2_floor;
    logic [15:0] aging_threshold;
    logic [7:0]  aging_step;
    logic [7:0]  priority_cap;
    logic [15:0] time_quantum;
  } cfg_t;

endpackage

>>> rtl/tlfq_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module tlfq_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output tlfq_pkg::cfg_t cfg
);
  import tlfq_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.l1_floor        <= 8'd100;
      cfg.l2_floor        <= 8'd50;
      cfg.aging_threshold <= 16'd1500;
      cfg.aging_step      <= 8'd10;
      cfg.priority_cap    <= 8'd149;
      cfg.time_quantum    <= 16'd100;
    end else if (wr) begin
      unique case (idx)
        RegL1Floor:   cfg.l1_floor        <= pwdata[7:0];
        RegL2Floor:   cfg.l2_floor        <= pwdata[7:0];
        RegAgingThr:  cfg.aging_threshold <= pwdata[15:0];
        RegAgingStep: cfg.aging_step      <= pwdata[7:0];
        RegPrioCap:   cfg.priority_cap    <= pwdata[7:0];
        RegQuantum:   cfg.time_quantum    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegL1Floor:   prdata = {24'd0, cfg.l1_floor};
      RegL2Floor:   prdata = {24'd0, cfg.l2_floor};
      RegAgingThr:  prdata = {16'd0, cfg.aging_threshold};
      RegAgingStep: prdata = {24'd0, cfg.aging_step};
      RegPrioCap:   prdata = {24'd0, cfg.priority_cap};
      RegQuantum:   prdata = {16'd0, cfg.time_quantum};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/tlfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_ram
// entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module tlfq_ram (
  input  logic clk,
  input  logic we,
  input  logic [tlfq_pkg::SlotW-1:0] waddr,
  input  tlfq_pkg::entry_t wdata,
  input  logic [tlfq_pkg::SlotW-1:0] raddr,
  output tlfq_pkg::entry_t rdata
);
  import tlfq_pkg::*;

  entry_t mem [TableDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/three_level_feedback_queue_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler_core
// ready table of up to 32 threads in three levels, scanned from one memory
// ----------------------------------------------------------------------------
//  channel  signals                         direction
//  in       in_valid in_ready in_data       item from scheduler
//  out      out_valid out_ready out_data    one result per item
//  cfg      psel penable pwrite paddr ...   apb register access
//
// insert passes from idle through the done state, where its result is registered.
// remove, age and preempt scan the entry memory once, one slot a cycle through
// the registered read port, then pass the done state, where the result is
// registered; the next word is taken once the block is back in idle.
// the scan rate is set by the single read port of the entry memory.
// valid bits and the insert counter live in flops and clear on reset.
// a waiting result does not block the next item; a second waits on out_ready.
module three_level_feedback_queue_scheduler_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  tlfq_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output tlfq_pkg::out_word_t out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlfq_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  cfg_t cfg;
  tlfq_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );
  assign pready = 1'b1;

  logic [1:0]  state;
  in_word_t    item;
  logic [TableDepth-1:0] valid;
  logic [15:0] insert_counter;
  logic [CntW-1:0] rd_cnt;
  logic        rd_pend;
  logic [SlotW-1:0] rd_slot;

  // best found so far per level
  logic [2:0]  has;
  logic [SlotW-1:0] bslot [3];
  entry_t      bent [3];

  logic        we;
  logic [SlotW-1:0] waddr;
  entry_t      wdata;
  entry_t      rdata;
  logic [SlotW-1:0] raddr;

  tlfq_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  // lowest free slot
  logic [SlotW-1:0] free_slot;
  logic             full;
  always_comb begin
    free_slot = '0;
    full = 1'b1;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = SlotW'(i);
        full = 1'b0;
      end
    end
  end

  assign raddr = rd_cnt[SlotW-1:0];

  logic [1:0] ins_lv;
  assign ins_lv = (item.priority_req >= cfg.l1_floor) ? Level1 :
                  (item.priority_req >= cfg.l2_floor) ? Level2 : Level3;

  // compare scanned entry with current best of its level
  logic better;
  logic [15:0] age_a, age_b;
  logic [1:0]  lvi;
  assign lvi = rdata.level - 2'd1;
  always_comb begin
    age_a = insert_counter - rdata.order;
    age_b = insert_counter - bent[lvi].order;
    better = 1'b0;
    unique case (rdata.level)
      Level1: better = ($signed(rdata.sort_key) != $signed(bent[lvi].sort_key)) ?
                       ($signed(rdata.sort_key) < $signed(bent[lvi].sort_key)) :
                       (rdata.id < bent[lvi].id);
      Level2: better = (rdata.sort_key != bent[lvi].sort_key) ?
                       (rdata.sort_key > bent[lvi].sort_key) : (rdata.id < bent[lvi].id);
      default: better = (age_a != age_b) ? (age_a > age_b) : (rdata.id < bent[lvi].id);
    endcase
  end

  logic        aged;
  logic [8:0]  np;
  assign aged = (item.now_tick - rdata.ready_since) > {16'd0, cfg.aging_threshold};
  assign np   = {1'b0, rdata.prio} + {1'b0, cfg.aging_step};

  // result register with one spare slot
  out_word_t res, hold;
  logic      res_v, hold_v;
  logic      res_push;
  out_word_t res_word;

  assign in_ready = (state == StIdle) && !hold_v;

  logic [TableDepth-1:0] valid_after;
  logic [SlotW-1:0] rm_slot;
  logic [1:0] rm_lv;
  always_comb begin
    rm_lv = LevelNone;
    rm_slot = '0;
    if (has[0]) begin rm_lv = Level1; rm_slot = bslot[0]; end
    else if (has[1]) begin rm_lv = Level2; rm_slot = bslot[1]; end
    else if (has[2]) begin rm_lv = Level3; rm_slot = bslot[2]; end
  end

  always_comb begin
    we = 1'b0;
    waddr = rd_slot;
    wdata = rdata;
    res_push = 1'b0;
    res_word = '0;
    valid_after = valid;
    if (state == StIdle && in_valid && in_ready && in_data.mode == ModeInsert) begin
      // insert handled in done stage
    end
    if (state == StScan && rd_pend && item.mode == ModeAge && valid[rd_slot] && aged) begin
      we = 1'b1;
      wdata.prio = (np > {1'b0, cfg.priority_cap}) ? cfg.priority_cap : np[7:0];
      wdata.ready_since = item.now_tick;
    end
    if (state == StDone) begin
      res_push = 1'b1;
      unique case (item.mode)
        ModeInsert: begin
          if (full) res_word.dropped = 1'b1;
          else begin
            we = 1'b1;
            waddr = free_slot;
            wdata.id = item.thread_id;
            wdata.level = ins_lv;
            wdata.prio = item.priority_req;
            wdata.sort_key = (ins_lv == Level1) ? item.remaining_time :
                             (ins_lv == Level2) ? {24'd0, item.priority_req} : 32'd0;
            wdata.ready_since = item.now_tick;
            wdata.order = insert_counter;
            valid_after[free_slot] = 1'b1;
          end
        end
        ModeRemove: begin
          if (rm_lv != LevelNone) begin
            res_word.found = 1'b1;
            res_word.out_id = bent[rm_lv - 2'd1].id;
            res_word.out_priority = bent[rm_lv - 2'd1].prio;
            res_word.out_level = rm_lv;
            valid_after[rm_slot] = 1'b0;
          end
        end
        ModeAge: ;
        ModePreempt: begin
          unique case (item.running_level)
            Level1: res_word.preempt = has[0] &&
                      ($signed(bent[0].sort_key) < item.running_remaining);
            Level2: res_word.preempt = has[0];
            Level3: res_word.preempt = has[0] || has[1] ||
                      (item.running_burst > {16'd0, cfg.time_quantum});
            default: res_word.preempt = 1'b0;
          endcase
        end
        default: ;
      endcase
      res_word.all_empty = (valid_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      valid <= '0;
      insert_counter <= '0;
      rd_cnt <= '0;
      rd_pend <= 1'b0;
      has <= '0;
    end else begin
      unique case (state)
        StIdle: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            has <= '0;
            rd_cnt <= '0;
            rd_pend <= 1'b0;
            state <= (in_data.mode == ModeInsert) ? StDone : StScan;
          end
        end
        StScan: begin
          rd_pend <= (rd_cnt < CntW'(TableDepth));
          rd_slot <= raddr;
          if (rd_cnt < CntW'(TableDepth)) rd_cnt <= rd_cnt + 1'b1;
          if (rd_pend && valid[rd_slot] && rdata.level != LevelNone &&
              (!has[lvi] || better)) begin
            has[lvi] <= 1'b1;
            bslot[lvi] <= rd_slot;
            bent[lvi] <= rdata;
          end
          if (rd_cnt == CntW'(TableDepth) && rd_pend) state <= StDone;
        end
        StDone: begin
          valid <= valid_after;
          if (item.mode == ModeInsert && !full) insert_counter <= insert_counter + 16'd1;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  // output register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
      hold_v <= 1'b0;
    end else begin
      if (res_v && out_ready) begin
        res_v <= hold_v || res_push;
        if (hold_v) begin
          res <= hold;
          hold_v <= res_push;
          if (res_push) hold <= res_word;
        end else if (res_push) res <= res_word;
      end else if (!res_v) begin
        res_v <= res_push;
        if (res_push) res <= res_word;
      end else if (res_push) begin
        hold <= res_word;
        hold_v <= 1'b1;
      end
    end
  end

  assign out_valid = res_v;
  assign out_data  = res;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !in_ready) else $error("item taken while busy");
  a_hold_needs_res: assert property (@(posedge clk) disable iff (rst)
    hold_v |-> res_v) else $error("skid slot filled ahead of output");
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == StDone) |=> (state == StIdle)) else $error("done stage stuck");
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (state != StDone) |=> $stable(insert_counter)) else $error("counter moved");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the three-level ready table against a cycle-free predictor: a short
// table of directed words, then random insert/remove/age/preempt traffic in
// several register settings, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;
  import tlfq_pkg::*;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } stim_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_word_t in_data;
  out_word_t out_data;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  three_level_feedback_queue_scheduler_core dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // shadow of the table
  cfg_t        sh_cfg;
  bit          sh_valid [TableDepth];
  logic [15:0] sh_id [TableDepth];
  logic [1:0]  sh_level [TableDepth];
  logic [7:0]  sh_prio [TableDepth];
  logic [31:0] sh_key [TableDepth];
  logic [31:0] sh_since [TableDepth];
  logic [15:0] sh_order [TableDepth];
  logic [15:0] sh_inserts;

  out_word_t pending_results [$];
  int errors = 0;
  int cyc = 0;
  logic [31:0] tick = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bit slot_beats(int lv, int a, int b);
    logic [15:0] age_a, age_b;
    age_a = sh_inserts - sh_order[a];
    age_b = sh_inserts - sh_order[b];
    if (lv == Level1 && sh_key[a] != sh_key[b])
      return $signed(sh_key[a]) < $signed(sh_key[b]);
    if (lv == Level2 && sh_key[a] != sh_key[b]) return sh_key[a] > sh_key[b];
    if (lv == Level3 && age_a != age_b) return age_a > age_b;
    return sh_id[a] < sh_id[b];
  endfunction

  function automatic int best_slot(int lv);
    int b;
    b = -1;
    for (int i = 0; i < TableDepth; i++)
      if (sh_valid[i] && sh_level[i] == lv && (b < 0 || slot_beats(lv, i, b))) b = i;
    return b;
  endfunction

  function automatic out_word_t schedule_step(in_word_t w);
    out_word_t r;
    int s, b1;
    logic [1:0] lv;
    logic [8:0] np;
    r = '0;
    s = -1;
    case (w.mode)
      ModeInsert: begin
        for (int i = TableDepth - 1; i >= 0; i--) if (!sh_valid[i]) s = i;
        if (s < 0) r.dropped = 1;
        else begin
          lv = (w.priority_req >= sh_cfg.l1_floor) ? Level1 :
               (w.priority_req >= sh_cfg.l2_floor) ? Level2 : Level3;
          sh_valid[s] = 1;
          sh_id[s] = w.thread_id;
          sh_level[s] = lv;
          sh_prio[s] = w.priority_req;
          sh_key[s] = (lv == Level1) ? w.remaining_time :
                      (lv == Level2) ? {24'd0, w.priority_req} : 32'd0;
          sh_since[s] = w.now_tick;
          sh_order[s] = sh_inserts;
          sh_inserts++;
        end
      end
      ModeRemove: begin
        for (int l = Level1; l <= Level3 && s < 0; l++) s = best_slot(l);
        if (s >= 0) begin
          r.found = 1;
          r.out_id = sh_id[s];
          r.out_priority = sh_prio[s];
          r.out_level = sh_level[s];
          sh_valid[s] = 0;
        end
      end
      ModeAge: begin
        for (int i = 0; i < TableDepth; i++)
          if (sh_valid[i] && (w.now_tick - sh_since[i]) > {16'd0, sh_cfg.aging_threshold}) begin
            np = sh_prio[i] + sh_cfg.aging_step;
            sh_prio[i] = (np > sh_cfg.priority_cap) ? sh_cfg.priority_cap : np[7:0];
            sh_since[i] = w.now_tick;
          end
      end
      default: begin
        b1 = best_slot(Level1);
        case (w.running_level)
          Level1: r.preempt = b1 >= 0 && $signed(sh_key[b1]) < w.running_remaining;
          Level2: r.preempt = b1 >= 0;
          Level3: r.preempt = b1 >= 0 || best_slot(Level2) >= 0 ||
                              w.running_burst > {16'd0, sh_cfg.time_quantum};
          default: r.preempt = 0;
        endcase
      end
    endcase
    r.all_empty = 1;
    for (int i = 0; i < TableDepth; i++) if (sh_valid[i]) r.all_empty = 0;
    return r;
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    out_word_t p;
    @(negedge clk);
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    p = schedule_step(w);
    pending_results.push_back(typed ? res : p);
    @(negedge clk);
    in_valid <= 0;
    if (cyc < 3000 || cyc >= 9000) begin
      if ($urandom_range(99) < 15) repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegL1Floor:   sh_cfg.l1_floor = val[7:0];
      RegL2Floor:   sh_cfg.l2_floor = val[7:0];
      RegAgingThr:  sh_cfg.aging_threshold = val[15:0];
      RegAgingStep: sh_cfg.aging_step = val[7:0];
      RegPrioCap:   sh_cfg.priority_cap = val[7:0];
      default:      sh_cfg.time_quantum = val[15:0];
    endcase
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain_table();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_word_t random_word(int fill_bias);
    in_word_t w;
    int pick;
    w.mode = ($urandom_range(99) < fill_bias) ? ModeInsert : ModeRemove;
    pick = $urandom_range(99);
    if (pick < 10) w.mode = ModeAge;
    else if (pick < 22) w.mode = ModePreempt;
    w.thread_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
    w.priority_req = 8'($urandom_range(149));
    w.remaining_time = ($urandom_range(1) == 0) ? 32'($urandom) :
                       32'(int'($urandom_range(8)) - 4);
    tick = tick + $urandom_range(1200);
    if ($urandom_range(15) == 0) tick = $urandom;
    w.now_tick = tick;
    w.running_level = 2'($urandom_range(3));
    w.running_remaining = ($urandom_range(1) == 0) ? 32'($urandom) :
                          32'(int'($urandom_range(8)) - 4);
    w.running_burst = ($urandom_range(1) == 0) ? $urandom : $urandom_range(200);
    return w;
  endfunction

  task automatic random_burst(int n);
    int bias;
    for (int k = 0; k < n; k++) begin
      // alternate filling and draining so the table sees full and empty
      bias = ((k / 60) % 2 == 0) ? 80 : 25;
      send_word(random_word(bias), 0, '0);
    end
  endtask

  function automatic in_word_t mk(logic [1:0] m, logic [15:0] id, logic [7:0] p,
                                  logic [31:0] rt, logic [31:0] now, logic [1:0] rl,
                                  logic [31:0] rr, logic [31:0] rb);
    in_word_t w;
    w = '{m, id, p, rt, now, rl, rr, rb};
    return w;
  endfunction

  task automatic check_field(string name, longint got, longint want);
    if (got != want) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: random stalls, a clean stretch and one long hold-off
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= 3000 && cyc < 6000) out_ready <= 1;
    else if (cyc >= 6000 && cyc < 6800) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", out_data.found, want.found);
        check_field("out_id", out_data.out_id, want.out_id);
        check_field("out_priority", out_data.out_priority, want.out_priority);
        check_field("out_level", out_data.out_level, want.out_level);
        check_field("all_empty", out_data.all_empty, want.all_empty);
        check_field("preempt", out_data.preempt, want.preempt);
        check_field("dropped", out_data.dropped, want.dropped);
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    out_word_t idle_empty;
    int waited;
    rst = 1; in_valid = 0; in_data = '0; out_ready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    sh_cfg = '{8'd100, 8'd50, 16'd1500, 8'd10, 8'd149, 16'd100};
    for (int i = 0; i < TableDepth; i++) sh_valid[i] = 0;
    sh_inserts = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    idle_empty = '0;
    idle_empty.all_empty = 1;
    rows.push_back('{mk(ModeRemove, 0, 0, 0, 0, 0, 0, 0), 1, idle_empty});
    rows.push_back('{mk(ModePreempt, 0, 0, 0, 0, LevelNone, 0, '1), 1, idle_empty});
    rows.push_back('{mk(ModeAge, 0, 0, 0, '1, 0, 0, 0), 1, idle_empty});
    rows.push_back('{mk(ModePreempt, 0, 0, 0, 0, Level3, 0, 101), 0, '0});
    rows.push_back('{mk(ModeInsert, 7, 149, 32'h8000_0000, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ModeInsert, 9, 100, 32'h7fff_ffff, 10, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ModeInsert, 8, 120, 32'h8000_0000, 20, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ModeInsert, 16'hffff, 99, '1, 30, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ModeInsert, 5, 50, 0, 40, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ModeInsert, 3, 0, 0, 50, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ModeInsert, 2, 49, 0, 60, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ModePreempt, 0, 0, 0, 0, Level1, 32'h8000_0000, 0), 0, '0});
    rows.push_back('{mk(ModePreempt, 0, 0, 0, 0, Level1, 32'h7fff_ffff, 0), 0, '0});
    rows.push_back('{mk(ModePreempt, 0, 0, 0, 0, Level2, 0, 0), 0, '0});
    rows.push_back('{mk(ModeAge, 0, 0, 0, 1540, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ModeAge, 0, 0, 0, '1, 0, 0, 0), 0, '0});
    for (int i = 0; i < 7; i++)
      rows.push_back('{mk(ModeRemove, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

    random_burst(300);
    drain_table();
    // every level one, aging every tick, zero quantum
    reg_write(RegL1Floor, 0);
    reg_write(RegL2Floor, 0);
    reg_write(RegAgingThr, 0);
    reg_write(RegAgingStep, 149);
    reg_write(RegPrioCap, 0);
    reg_write(RegQuantum, 0);
    random_burst(200);
    drain_table();
    // only priority 149 reaches level one, level two stays empty, aging only past a 65535 tick gap
    reg_write(RegL1Floor, 149);
    reg_write(RegL2Floor, 149);
    reg_write(RegAgingThr, 16'hffff);
    reg_write(RegAgingStep, 0);
    reg_write(RegPrioCap, 149);
    reg_write(RegQuantum, 16'hffff);
    random_burst(250);
    drain_table();
    // floors swapped: level one still tested first
    reg_write(RegL1Floor, 50);
    reg_write(RegL2Floor, 100);
    reg_write(RegAgingThr, 600);
    reg_write(RegAgingStep, 37);
    reg_write(RegPrioCap, 120);
    reg_write(RegQuantum, 100);
    random_burst(430);

    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tlfq_pkg.sv
rtl/tlfq_regs.sv
rtl/tlfq_ram.sv
rtl/three_level_feedback_queue_scheduler_core.sv
tb/tb_top.sv
